// ===== hw/rtl/htwc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htwc_pkg
// Types, constants and coefficient table of the hit time walk correction.
// ----------------------------------------------------------------------------
package htwc_pkg;

  localparam int COEF_W    = 32;
  localparam int NUM_TERMS = 6;
  localparam int NUM_SETS  = 9;
  localparam int IDX_W     = 6;
  localparam int TS_W      = 48;
  localparam int E_W       = 24;
  localparam int POS_W     = 20;
  localparam int SQ_W      = 40;
  localparam int CT_W      = 49;
  localparam int CORR_W    = 32;
  localparam int DIV_W     = 64;
  localparam int E3_W      = 61;

  localparam logic [2:0] MOD_A     = 3'd3;
  localparam logic [2:0] MOD_B     = 3'd5;
  localparam logic [7:0] FEW_HITS  = 8'd3;

  localparam logic [1:0] GRP_A     = 2'd0;
  localparam logic [1:0] GRP_B     = 2'd1;
  localparam logic [1:0] GRP_OTHER = 2'd2;

  localparam logic [1:0] KIND_SINGLE = 2'd0;
  localparam logic [1:0] KIND_MANY   = 2'd1;
  localparam logic [1:0] KIND_FEW    = 2'd2;

  localparam logic signed [COEF_W-1:0] COEF_TABLE [NUM_SETS*NUM_TERMS] = '{
    32'sd8584954, 32'sd362388, 32'sd170162913, -32'sd30208000, -32'sd190569, 32'sd736267,
    32'sd8613265, 32'sd2880312, -32'sd1688574362, 32'sd1313587200, -32'sd2109812500,
    32'sd1273288727,
    32'sd8960737, -32'sd9636833, 32'sd1007629107, -32'sd227123200, 32'sd46526250,
    -32'sd4446144,
    32'sd2728657, 32'sd14280766, 32'sd14522778, 32'sd9932800, -32'sd4735000, 32'sd612373,
    32'sd3422355, 32'sd10952167, -32'sd280703795, 32'sd186470400, -32'sd583562500,
    32'sd1081008911,
    32'sd2897084, 32'sd13529147, -32'sd73400320, 32'sd23040000, -32'sd60019, -32'sd149002,
    32'sd16136471, 32'sd9448928, -32'sd63281562, 32'sd43857920, -32'sd12500000,
    32'sd4786377,
    32'sd16156983, 32'sd8901320, -32'sd346239795, 32'sd298844160, -32'sd475000000,
    32'sd580516815,
    32'sd16028664, 32'sd11126650, 32'sd179904184, 32'sd27699200, -32'sd16310625,
    32'sd5438042
  };

  typedef struct packed {
    logic [TS_W-1:0]          ts;
    logic                     ezero;
    logic                     big;
    logic [SQ_W-1:0]          sqsum;
    logic signed [COEF_W-1:0] t0;
    logic [COEF_W-1:0]        c1_mag;
    logic [COEF_W-1:0]        c2_mag;
    logic [NUM_TERMS-1:0]     neg;
  } ctx1_t;

  typedef struct packed {
    ctx1_t            c;
    logic [DIV_W-1:0] q3;
    logic [DIV_W-1:0] q4;
    logic [DIV_W-1:0] q5;
  } ctx2_t;

  function automatic logic [IDX_W-1:0] set_base(input logic [2:0] mod, input logic clu,
                                                 input logic [7:0] hits);
    logic [1:0] grp;
    logic [1:0] kind;
    grp  = (mod == MOD_A) ? GRP_A : (mod == MOD_B) ? GRP_B : GRP_OTHER;
    kind = !clu ? KIND_SINGLE : (hits > FEW_HITS) ? KIND_MANY : KIND_FEW;
    return (IDX_W'(grp) * IDX_W'(3) + IDX_W'(kind)) * IDX_W'(NUM_TERMS);
  endfunction

  function automatic logic coef_neg(input logic [IDX_W-1:0] idx);
    return COEF_TABLE[idx] < 0;
  endfunction

  function automatic logic [COEF_W-1:0] coef_abs(input logic [IDX_W-1:0] idx);
    logic signed [COEF_W-1:0] c;
    c = COEF_TABLE[idx];
    return (c < 0) ? COEF_W'(-c) : COEF_W'(c);
  endfunction

  function automatic logic signed [COEF_W-1:0] t0_of(input logic [IDX_W-1:0] idx);
    logic [COEF_W-1:0] m;
    m = (coef_abs(idx) + COEF_W'(128)) >> 8;
    return coef_neg(idx) ? -$signed(m) : $signed(m);
  endfunction

endpackage

// ===== hw/rtl/htwc_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htwc_in_if / htwc_out_if
// Valid/ready channels for hit items and corrected results.
// ----------------------------------------------------------------------------
interface htwc_in_if;
  logic               valid;
  logic               ready;
  logic               is_cluster;
  logic [2:0]         module_req;
  logic [7:0]         hit_count;
  logic [47:0]        timestamp;
  logic [23:0]        energy;
  logic signed [19:0] pos_x;
  logic signed [19:0] pos_y;
  logic signed [19:0] pos_z;

  modport source(output valid, is_cluster, module_req, hit_count, timestamp, energy,
                 pos_x, pos_y, pos_z, input ready);
  modport sink(input valid, is_cluster, module_req, hit_count, timestamp, energy,
               pos_x, pos_y, pos_z, output ready);
endinterface

interface htwc_out_if;
  logic               valid;
  logic               ready;
  logic signed [48:0] corrected_time;
  logic signed [31:0] correction;
  logic               saturated;
  logic               energy_zero;

  modport source(output valid, corrected_time, correction, saturated, energy_zero,
                 input ready);
  modport sink(input valid, corrected_time, correction, saturated, energy_zero,
               output ready);
endinterface

// ===== hw/rtl/hit_time_walk_correction.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hit_time_walk_correction
// Subtracts an energy and path dependent walk correction from hit times.
// ----------------------------------------------------------------------------
// Stages from accepted item to result valid: 4 setup stages,
// 64 divider stages, 32 square root stages, 4 multiply/sum stages, 1 output.
// Throughput one item per cycle; a stalled output holds the whole pipeline.
// Synchronous reset clears the valid bits only; the table is constant.
// ----------------------------------------------------------------------------
module hit_time_walk_correction (
  input  logic              clk,
  input  logic              rst_n,
  htwc_in_if.sink           in_ch,
  htwc_out_if.source        out_ch
);
  import htwc_pkg::*;

  function automatic logic signed [DIV_W-1:0] apply_sign(input logic [DIV_W-1:0] m,
                                                          input logic n);
    return n ? -$signed(m) : $signed(m);
  endfunction

  localparam logic signed [DIV_W-1:0] CORR_MAX = (DIV_W'(1) <<< (CORR_W-1)) - 1;
  localparam logic signed [DIV_W-1:0] CORR_MIN = -(DIV_W'(1) <<< (CORR_W-1));
  localparam logic signed [TS_W+1:0]  CT_MAX   = (TS_W+2)'((TS_W+2)'(1) << TS_W) - 1;

  logic en;

  // setup stages
  logic                    v1_r, v2_r, v3_r, v4_r;
  logic [TS_W-1:0]         ts1_r, ts2_r, ts3_r, ts4_r;
  logic [E_W-1:0]          e1_r, e2_r, e3_r, e4_r;
  logic [IDX_W-1:0]        base1_r, base2_r, base3_r, base4_r;
  logic signed [POS_W-1:0] x1_r, y1_r, z1_r;
  logic [SQ_W-1:0]         sqx_r, sqy_r, sqz_r, sqsum3_r, sqsum4_r;
  logic [2*E_W-1:0]        ee2_2_r, ee2_3_r, ee2_4_r, plo_r, phi_r;
  logic [E3_W-1:0]         ee3_r;
  logic [3*E_W-1:0]        ee3_sum;

  assign en          = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;
  assign ee3_sum     = {phi_r, {E_W{1'b0}}} + (3*E_W)'(plo_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_ch.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ts1_r   <= in_ch.timestamp;
      e1_r    <= in_ch.energy;
      base1_r <= set_base(in_ch.module_req, in_ch.is_cluster, in_ch.hit_count);
      x1_r    <= in_ch.pos_x;
      y1_r    <= in_ch.pos_y;
      z1_r    <= in_ch.pos_z;

      ts2_r   <= ts1_r;
      e2_r    <= e1_r;
      base2_r <= base1_r;
      sqx_r   <= SQ_W'(x1_r * x1_r);
      sqy_r   <= SQ_W'(y1_r * y1_r);
      sqz_r   <= SQ_W'(z1_r * z1_r);
      ee2_2_r <= e1_r * e1_r;

      ts3_r    <= ts2_r;
      e3_r     <= e2_r;
      base3_r  <= base2_r;
      sqsum3_r <= sqx_r + sqy_r + sqz_r;
      ee2_3_r  <= ee2_2_r;
      plo_r    <= ee2_2_r[E_W-1:0] * e2_r;
      phi_r    <= ee2_2_r[2*E_W-1:E_W] * e2_r;

      ts4_r    <= ts3_r;
      e4_r     <= e3_r;
      base4_r  <= base3_r;
      sqsum4_r <= sqsum3_r;
      ee2_4_r  <= ee2_3_r;
      ee3_r    <= ee3_sum[E3_W-1:0];
    end
  end

  // divider stage
  ctx1_t            ctx1_in, ctx1_out;
  logic [DIV_W-1:0] n3, n4, n5, q0, q3, q4, q5;
  logic             dv_vld;

  always_comb begin
    ctx1_in.ts     = ts4_r;
    ctx1_in.ezero  = (e4_r == '0);
    ctx1_in.big    = (e4_r[E_W-1:20] != '0);
    ctx1_in.sqsum  = sqsum4_r;
    ctx1_in.t0     = t0_of(base4_r);
    ctx1_in.c1_mag = coef_abs(IDX_W'(base4_r + IDX_W'(1)));
    ctx1_in.c2_mag = coef_abs(IDX_W'(base4_r + IDX_W'(2)));
    for (int k = 0; k < NUM_TERMS; k++) begin
      ctx1_in.neg[k] = coef_neg(IDX_W'(base4_r + IDX_W'(k)));
    end
  end

  assign n3 = DIV_W'({coef_abs(IDX_W'(base4_r + IDX_W'(3))), 1'b0}) + DIV_W'({e4_r, 2'b00});
  assign n4 = DIV_W'({coef_abs(IDX_W'(base4_r + IDX_W'(4))), 13'b0}) + DIV_W'(ee2_4_r);
  assign n5 = DIV_W'({coef_abs(IDX_W'(base4_r + IDX_W'(5))), 27'b0}) + DIV_W'(ee3_r);

  htwc_iter #(.SQRT(1'b0), .NW(DIV_W), .DW(E_W), .SW($bits(ctx1_t))) u_div_r (
    .clk, .rst_n, .en, .i_vld(v4_r), .i_n(DIV_W'(1) << 62), .i_d(e4_r), .i_sb(ctx1_in),
    .o_vld(dv_vld), .o_q(q0), .o_sb(ctx1_out)
  );

  htwc_iter #(.SQRT(1'b0), .NW(DIV_W), .DW(E_W+3), .SW(1)) u_div_3 (
    .clk, .rst_n, .en, .i_vld(v4_r), .i_n(n3), .i_d({e4_r, 3'b000}), .i_sb(1'b0),
    .o_vld(), .o_q(q3), .o_sb()
  );

  htwc_iter #(.SQRT(1'b0), .NW(DIV_W), .DW(2*E_W+1), .SW(1)) u_div_4 (
    .clk, .rst_n, .en, .i_vld(v4_r), .i_n(n4), .i_d({ee2_4_r, 1'b0}), .i_sb(1'b0),
    .o_vld(), .o_q(q4), .o_sb()
  );

  htwc_iter #(.SQRT(1'b0), .NW(DIV_W), .DW(E3_W+1), .SW(1)) u_div_5 (
    .clk, .rst_n, .en, .i_vld(v4_r), .i_n(n5), .i_d({ee3_r, 1'b0}), .i_sb(1'b0),
    .o_vld(), .o_q(q5), .o_sb()
  );

  // square root stage
  ctx2_t            ctx2_in, ctx2_out;
  logic [DIV_W-1:0] rinv, path;
  logic             sq_vld;

  assign ctx2_in = '{c: ctx1_out, q3: q3, q4: q4, q5: q5};

  htwc_iter #(.SQRT(1'b1), .NW(DIV_W), .DW(DIV_W/2), .SW($bits(ctx2_t))) u_sqrt_r (
    .clk, .rst_n, .en, .i_vld(dv_vld), .i_n(q0), .i_d('0), .i_sb(ctx2_in),
    .o_vld(sq_vld), .o_q(rinv), .o_sb(ctx2_out)
  );

  htwc_iter #(.SQRT(1'b1), .NW(DIV_W), .DW(DIV_W/2), .SW(1)) u_sqrt_p (
    .clk, .rst_n, .en, .i_vld(dv_vld), .i_n(DIV_W'(ctx1_out.sqsum)), .i_d('0), .i_sb(1'b0),
    .o_vld(), .o_q(path), .o_sb()
  );

  // multiply, round and sum
  logic                    v5_r, v6_r, v7_r, v8_r;
  ctx2_t                   c5_r;
  logic [DIV_W-1:0]        p1_r, p2_r;
  logic [TS_W-1:0]         ts6_r, ts7_r, ts8_r;
  logic                    ez6_r, ez7_r, ez8_r;
  logic signed [DIV_W-1:0] t_r [NUM_TERMS];
  logic signed [DIV_W-1:0] s01_r, s23_r, s45_r, sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
      v8_r <= 1'b0;
    end else if (en) begin
      v5_r <= sq_vld;
      v6_r <= v5_r;
      v7_r <= v6_r;
      v8_r <= v7_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c5_r <= ctx2_out;
      p1_r <= DIV_W'(ctx2_out.c.c1_mag * path[DIV_W/2-1:0]);
      p2_r <= DIV_W'(ctx2_out.c.c2_mag * rinv[DIV_W/2-1:0]);

      ts6_r  <= c5_r.c.ts;
      ez6_r  <= c5_r.c.ezero;
      t_r[0] <= DIV_W'(c5_r.c.t0);
      t_r[1] <= apply_sign((p1_r + (DIV_W'(1) << 27)) >> 28, c5_r.c.neg[1]);
      t_r[2] <= apply_sign((p2_r + (DIV_W'(1) << 41)) >> 42, c5_r.c.neg[2]);
      t_r[3] <= apply_sign(c5_r.q3, c5_r.c.neg[3]);
      t_r[4] <= apply_sign(c5_r.q4, c5_r.c.neg[4]);
      t_r[5] <= c5_r.c.big ? '0 : apply_sign(c5_r.q5, c5_r.c.neg[5]);

      ts7_r <= ts6_r;
      ez7_r <= ez6_r;
      s01_r <= t_r[0] + t_r[1];
      s23_r <= t_r[2] + t_r[3];
      s45_r <= t_r[4] + t_r[5];

      ts8_r <= ts7_r;
      ez8_r <= ez7_r;
      sum_r <= s01_r + s23_r + s45_r;
    end
  end

  // saturate and apply
  logic                     out_vld_r;
  logic signed [CT_W-1:0]   out_ct_r;
  logic signed [CORR_W-1:0] out_corr_r;
  logic                     out_sat_r, out_ez_r;
  logic signed [CORR_W-1:0] corr_nxt;
  logic                     sat_nxt;
  logic signed [TS_W+1:0]   ct_full;

  always_comb begin
    sat_nxt  = 1'b0;
    corr_nxt = CORR_W'(sum_r);
    if (ez8_r) begin
      corr_nxt = '0;
    end else if (sum_r > CORR_MAX) begin
      corr_nxt = CORR_W'(CORR_MAX);
      sat_nxt  = 1'b1;
    end else if (sum_r < CORR_MIN) begin
      corr_nxt = CORR_W'(CORR_MIN);
      sat_nxt  = 1'b1;
    end
    ct_full = $signed({2'b00, ts8_r}) - (TS_W+2)'(corr_nxt);
    if (ct_full > CT_MAX) begin
      ct_full = CT_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= v8_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_ct_r   <= CT_W'(ct_full);
      out_corr_r <= corr_nxt;
      out_sat_r  <= sat_nxt;
      out_ez_r   <= ez8_r;
    end
  end

  assign out_ch.valid          = out_vld_r;
  assign out_ch.corrected_time = out_ct_r;
  assign out_ch.correction     = out_corr_r;
  assign out_ch.saturated      = out_sat_r;
  assign out_ch.energy_zero    = out_ez_r;

endmodule

// ===== hw/rtl/htwc_iter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htwc_iter
// Pipelined restoring divider or square root, one result bit per stage.
// Square root keeps its partial root in the divisor lane (seed with zero).
// ----------------------------------------------------------------------------
module htwc_iter #(
  parameter bit SQRT = 1'b0,
  parameter int NW   = 64,
  parameter int DW   = 24,
  parameter int SW   = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          i_vld,
  input  logic [NW-1:0] i_n,
  input  logic [DW-1:0] i_d,
  input  logic [SW-1:0] i_sb,
  output logic          o_vld,
  output logic [NW-1:0] o_q,
  output logic [SW-1:0] o_sb
);

  localparam int ST = SQRT ? NW / 2 : NW;
  localparam int RW = SQRT ? NW / 2 + 1 : DW;

  logic [ST-1:0] vld_r;
  logic [NW-1:0] nq_r  [ST];
  logic [RW-1:0] rem_r [ST];
  logic [DW-1:0] d_r   [ST];
  logic [SW-1:0] sb_r  [ST];

  for (genvar k = 0; k < ST; k++) begin : g_step
    logic          v_in;
    logic [NW-1:0] nq_in;
    logic [RW-1:0] rem_in;
    logic [DW-1:0] d_in;
    logic [SW-1:0] sb_in;
    logic [NW-1:0] nq_nxt;
    logic [RW-1:0] rem_nxt;
    logic [DW-1:0] d_nxt;

    if (k == 0) begin : g_first
      assign v_in   = i_vld;
      assign nq_in  = i_n;
      assign rem_in = '0;
      assign d_in   = i_d;
      assign sb_in  = i_sb;
    end else begin : g_next
      assign v_in   = vld_r[k-1];
      assign nq_in  = nq_r[k-1];
      assign rem_in = rem_r[k-1];
      assign d_in   = d_r[k-1];
      assign sb_in  = sb_r[k-1];
    end

    if (SQRT) begin : g_sqrt
      logic [RW+1:0] rt;
      logic [RW+1:0] tr;
      logic          ge;
      assign rt      = {rem_in, nq_in[NW-1:NW-2]};
      assign tr      = (RW+2)'({d_in, 2'b01});
      assign ge      = rt >= tr;
      assign rem_nxt = ge ? RW'(rt - tr) : RW'(rt);
      assign d_nxt   = {d_in[DW-2:0], ge};
      assign nq_nxt  = {nq_in[NW-3:0], 2'b00};
    end else begin : g_div
      logic [DW:0] rt;
      logic        ge;
      assign rt      = {rem_in, nq_in[NW-1]};
      assign ge      = rt >= {1'b0, d_in};
      assign rem_nxt = ge ? DW'(rt - {1'b0, d_in}) : DW'(rt);
      assign d_nxt   = d_in;
      assign nq_nxt  = {nq_in[NW-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        nq_r[k]  <= nq_nxt;
        rem_r[k] <= rem_nxt;
        d_r[k]   <= d_nxt;
        sb_r[k]  <= sb_in;
      end
    end
  end

  if (SQRT) begin : g_out_sqrt
    assign o_q = NW'(d_r[ST-1]);
  end else begin : g_out_div
    assign o_q = nq_r[ST-1];
  end

  assign o_vld = vld_r[ST-1];
  assign o_sb  = sb_r[ST-1];

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Streams hit items into the time walk correction block under random idling
// and backpressure, predicts each corrected time, correction and flags, and
// checks every result against the oldest pending prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import htwc_pkg::*;

  typedef struct {
    logic               is_cluster;
    logic [2:0]         module_req;
    logic [7:0]         hit_count;
    logic [47:0]        timestamp;
    logic [23:0]        energy;
    logic signed [19:0] pos_x;
    logic signed [19:0] pos_y;
    logic signed [19:0] pos_z;
  } hit_t;

  typedef struct {
    logic signed [48:0] corrected_time;
    logic signed [31:0] correction;
    logic               saturated;
    logic               energy_zero;
  } corr_res_t;

  logic clk;
  logic rst_n;
  int   errors;
  bit   no_idle;
  bit   hold_long;
  corr_res_t pending_q[$];

  htwc_in_if  in_ch();
  htwc_out_if out_ch();

  hit_time_walk_correction dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  initial begin
    #(12 * 600000);
    $display("FAIL hit_time_walk_correction");
    $finish;
  end

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint round_div(longint n, longint unsigned d);
    longint unsigned mag;
    longint unsigned q;
    mag = (n < 0) ? longint'(-n) : n;
    q = (2 * mag + d) / (2 * d);
    return (n < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic corr_res_t walk_correct(hit_t h);
    corr_res_t r;
    longint px, py, pz, sum, ct;
    longint unsigned path, rinv, e, e2;
    int grp, kind, base;
    r.saturated = 1'b0;
    r.energy_zero = 1'b0;
    sum = 0;
    e = h.energy;
    if (e == 0) begin
      r.energy_zero = 1'b1;
    end else begin
      grp  = (h.module_req == MOD_A) ? GRP_A : (h.module_req == MOD_B) ? GRP_B : GRP_OTHER;
      kind = !h.is_cluster ? KIND_SINGLE : (h.hit_count > FEW_HITS) ? KIND_MANY : KIND_FEW;
      base = (grp * 3 + kind) * NUM_TERMS;
      px = h.pos_x;
      py = h.pos_y;
      pz = h.pos_z;
      path = int_sqrt(px * px + py * py + pz * pz);
      rinv = int_sqrt((64'd1 << 62) / e);
      e2 = e * e;
      sum += round_div(longint'(COEF_TABLE[base]), 64'd1 << 8);
      sum += round_div(longint'(COEF_TABLE[base + 1]) * longint'(path), 64'd1 << 28);
      sum += round_div(longint'(COEF_TABLE[base + 2]) * longint'(rinv), 64'd1 << 42);
      sum += round_div(longint'(COEF_TABLE[base + 3]), e * 4);
      sum += round_div(longint'(COEF_TABLE[base + 4]) * 4096, e2);
      if (e < (64'd1 << 20))
        sum += round_div(longint'(COEF_TABLE[base + 5]) * (64'sd1 << 26), e2 * e);
      if (sum > 64'sd2147483647) begin
        sum = 64'sd2147483647;
        r.saturated = 1'b1;
      end else if (sum < -64'sd2147483648) begin
        sum = -64'sd2147483648;
        r.saturated = 1'b1;
      end
    end
    r.correction = sum[31:0];
    ct = longint'(h.timestamp) - sum;
    if (ct > (64'sd1 << 48) - 1) ct = (64'sd1 << 48) - 1;
    r.corrected_time = ct[48:0];
    return r;
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_hit(hit_t h);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.is_cluster <= h.is_cluster;
    in_ch.module_req <= h.module_req;
    in_ch.hit_count  <= h.hit_count;
    in_ch.timestamp  <= h.timestamp;
    in_ch.energy     <= h.energy;
    in_ch.pos_x      <= h.pos_x;
    in_ch.pos_y      <= h.pos_y;
    in_ch.pos_z      <= h.pos_z;
    forever begin
      @(posedge clk);
      if (in_ch.ready) break;
    end
    pending_q.push_back(walk_correct(h));
    @(negedge clk);
  endtask

  function automatic hit_t rand_hit();
    hit_t h;
    int w;
    h.is_cluster = 1'($urandom_range(0, 1));
    h.module_req = 3'($urandom_range(0, 7));
    h.hit_count  = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 6)) : 8'($urandom);
    h.timestamp  = 48'({$urandom, $urandom});
    if ($urandom_range(0, 7) == 0)
      h.timestamp = 48'hFFFF_FFFF_FFFF - 48'($urandom_range(0, 255));
    w = $urandom_range(0, 24);
    h.energy = 24'($urandom & ((32'd1 << w) - 1));
    if ($urandom_range(0, 3) == 0) begin
      w = $urandom_range(1, 20);
      h.pos_x = $signed(20'($urandom)) >>> (20 - w);
      h.pos_y = $signed(20'($urandom)) >>> (20 - w);
      h.pos_z = $signed(20'($urandom)) >>> (20 - w);
    end else begin
      h.pos_x = 20'($urandom);
      h.pos_y = 20'($urandom);
      h.pos_z = 20'($urandom);
    end
    return h;
  endfunction

  function automatic hit_t make_hit(logic clu, logic [2:0] m, logic [7:0] n, logic [47:0] ts,
                                    logic [23:0] e, logic signed [19:0] x,
                                    logic signed [19:0] y, logic signed [19:0] z);
    hit_t h;
    h.is_cluster = clu;
    h.module_req = m;
    h.hit_count  = n;
    h.timestamp  = ts;
    h.energy     = e;
    h.pos_x      = x;
    h.pos_y      = y;
    h.pos_z      = z;
    return h;
  endfunction

  task automatic test_directed();
    send_hit(make_hit(0, 3, 0, 48'd1000, 24'd0, 20'sd100, 20'sd0, 20'sd0));
    send_hit(make_hit(1, 5, 9, 48'hFFFF_FFFF_FFFF, 24'd0, -20'sd524288, 20'sd0, 20'sd0));
    send_hit(make_hit(1, 3, 255, 48'hFFFF_FFFF_FFFF, 24'd1, 20'sd0, 20'sd0, 20'sd0));
    send_hit(make_hit(1, 3, 4, 48'd0, 24'd1, 20'sd524287, 20'sd524287, 20'sd524287));
    send_hit(make_hit(1, 3, 3, 48'd0, 24'd1, -20'sd524288, -20'sd524288, -20'sd524288));
    send_hit(make_hit(1, 0, 0, 48'd5, 24'd2, 20'sd1, -20'sd1, 20'sd1));
    send_hit(make_hit(0, 1, 0, 48'd123456, 24'hFFFFFF, 20'sd2560, 20'sd0, 20'sd0));
    send_hit(make_hit(0, 2, 0, 48'd123456, 24'hFFFFF, 20'sd0, 20'sd2560, 20'sd0));
    send_hit(make_hit(0, 4, 0, 48'd123456, 24'h100000, 20'sd0, 20'sd0, 20'sd2560));
    send_hit(make_hit(0, 6, 0, 48'hFFFF_FFFF_FFFF, 24'd1000, 20'sd0, 20'sd0, 20'sd0));
    send_hit(make_hit(1, 7, 1, 48'hFFFF_FFFF_FF00, 24'd5, 20'sd0, 20'sd0, 20'sd0));
    send_hit(make_hit(1, 5, 4, 48'd777, 24'd1, 20'sd0, 20'sd0, 20'sd0));
    send_hit(make_hit(1, 5, 2, 48'd777, 24'd3, 20'sd300, 20'sd400, 20'sd0));
    send_hit(make_hit(0, 5, 200, 48'd777, 24'd1000000, 20'sd300, 20'sd400, 20'sd500));
    send_hit(make_hit(1, 2, 3, 48'd0, 24'd50, 20'sd0, 20'sd0, 20'sd0));
    send_hit(make_hit(1, 6, 4, 48'd0, 24'd50, 20'sd0, 20'sd0, 20'sd0));
    send_hit(make_hit(0, 3, 0, 48'd0, 24'd1, 20'sd0, 20'sd0, 20'sd0));
  endtask

  task automatic test_random(int count);
    repeat (count) send_hit(rand_hit());
  endtask

  task automatic test_stream(int count);
    no_idle = 1'b1;
    repeat (count) send_hit(rand_hit());
    no_idle = 1'b0;
  endtask

  task automatic test_backpressure();
    hold_long = 1'b1;
    repeat (300) send_hit(rand_hit());
  endtask

  task automatic test_drain();
    in_ch.valid <= 1'b0;
    wait (pending_q.size() == 0);
    @(negedge clk);
    test_random(50);
  endtask

  initial begin
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      int stall;
      if (hold_long) begin
        hold_long = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (400) @(negedge clk);
      end
      stall = no_idle ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      forever begin
        @(posedge clk);
        if (out_ch.valid) break;
      end
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      corr_res_t x;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result ct=%0d corr=%0d", $time,
                 out_ch.corrected_time, out_ch.correction);
        errors++;
      end else begin
        x = pending_q.pop_front();
        if (out_ch.corrected_time !== x.corrected_time) begin
          $display("%0t: corrected_time exp %0d got %0d", $time,
                   x.corrected_time, out_ch.corrected_time);
          errors++;
        end
        if (out_ch.correction !== x.correction) begin
          $display("%0t: correction exp %0d got %0d", $time, x.correction, out_ch.correction);
          errors++;
        end
        if (out_ch.saturated !== x.saturated) begin
          $display("%0t: saturated exp %0b got %0b", $time, x.saturated, out_ch.saturated);
          errors++;
        end
        if (out_ch.energy_zero !== x.energy_zero) begin
          $display("%0t: energy_zero exp %0b got %0b", $time,
                   x.energy_zero, out_ch.energy_zero);
          errors++;
        end
      end
    end
  end

  initial begin
    int waited;
    errors = 0;
    no_idle = 1'b0;
    hold_long = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.is_cluster = 1'b0;
    in_ch.module_req = '0;
    in_ch.hit_count = '0;
    in_ch.timestamp = '0;
    in_ch.energy = '0;
    in_ch.pos_x = '0;
    in_ch.pos_y = '0;
    in_ch.pos_z = '0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_random(900);
    test_stream(200);
    test_backpressure();
    test_drain();
    test_random(380);
    in_ch.valid <= 1'b0;
    waited = 0;
    while (pending_q.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (120) @(posedge clk);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("PASS hit_time_walk_correction");
    end else begin
      $display("FAIL hit_time_walk_correction");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/htwc_pkg.sv
hw/rtl/htwc_if.sv
hw/rtl/htwc_iter.sv
hw/rtl/hit_time_walk_correction.sv
dv/tb_top.sv
